/* rtl/core/ihsl_pkg.sv */
// ----------------------------------------------------------------------------
// ihsl_pkg
// Shared constants for the interleaved highpass slew limiter: default sizes,
// coefficient format, serial multiplier digit size and register map.
// ----------------------------------------------------------------------------
package ihsl_pkg;

	localparam int SAMPLE_BITS_DEF         = 24;
	localparam int STATE_FRACTION_BITS_DEF = 16;

	localparam int COEF_BITS      = 24;
	localparam int THRESHOLD_BITS = 23;
	localparam int DIGIT_BITS     = 2;
	localparam int COEF_DIGITS    = COEF_BITS / DIGIT_BITS;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 24;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_FAST_COEF = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SLOW_COEF = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD = 2'd2;

	localparam logic [COEF_BITS-1:0]      FAST_COEF_RST = 24'd6408290;
	localparam logic [COEF_BITS-1:0]      SLOW_COEF_RST = 24'd49493;
	localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RST = 23'd3204145;

endpackage

/* rtl/core/ihsl_in_if.sv */
// ----------------------------------------------------------------------------
// ihsl_in_if
// Input sample channel: valid/ready handshake carrying one signed sample.
// ----------------------------------------------------------------------------
interface ihsl_in_if #(
	parameter int SAMPLE_BITS = ihsl_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] in_sample;

	modport source (output valid, output in_sample, input ready);
	modport sink (input valid, input in_sample, output ready);
endinterface

/* rtl/core/ihsl_out_if.sv */
// ----------------------------------------------------------------------------
// ihsl_out_if
// Output sample channel: valid/ready handshake carrying one signed sample.
// ----------------------------------------------------------------------------
interface ihsl_out_if #(
	parameter int SAMPLE_BITS = ihsl_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_sample;

	modport source (output valid, output out_sample, input ready);
	modport sink (input valid, input out_sample, output ready);
endinterface

/* rtl/core/ihsl_mul.sv */
// ----------------------------------------------------------------------------
// ihsl_mul
// Digit-serial unsigned multiplier, two coefficient bits per cycle, LSB first.
// Returns floor(mag * coef / 2^COEF_BITS) and the highest dropped bit.
// ----------------------------------------------------------------------------
module ihsl_mul #(
	parameter int MAG_BITS = 41
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [MAG_BITS-1:0]            mag,
	input  logic [ihsl_pkg::COEF_BITS-1:0] coef,
	output logic                           done,
	output logic [MAG_BITS-1:0]            prod_hi,
	output logic                           round_bit
);
	import ihsl_pkg::*;

	localparam int ACC_BITS = MAG_BITS + DIGIT_BITS;
	localparam int CNT_BITS = $clog2(COEF_DIGITS);

	typedef enum logic [1:0] {
		MS_IDLE,
		MS_PREP,
		MS_RUN
	} mul_state_t;

	mul_state_t            state_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  done_q;
	logic [MAG_BITS-1:0]   mag_q;
	logic [ACC_BITS-1:0]   mag3_q;
	logic [ACC_BITS-1:0]   acc_q;
	logic [COEF_BITS-1:0]  lo_q;
	logic [ACC_BITS-1:0]   addend;
	logic [ACC_BITS-1:0]   sum;

	always_comb begin
		unique case (lo_q[DIGIT_BITS-1:0])
			2'd0:    addend = '0;
			2'd1:    addend = {{DIGIT_BITS{1'b0}}, mag_q};
			2'd2:    addend = {1'b0, mag_q, 1'b0};
			default: addend = mag3_q;
		endcase
		sum = acc_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MS_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				MS_IDLE: begin
					if (start) begin
						state_q <= MS_PREP;
					end
				end
				MS_PREP: begin
					cnt_q   <= '0;
					state_q <= MS_RUN;
				end
				MS_RUN: begin
					cnt_q <= cnt_q + CNT_BITS'(1);
					if (cnt_q == CNT_BITS'(COEF_DIGITS - 1)) begin
						done_q  <= 1'b1;
						state_q <= MS_IDLE;
					end
				end
				default: state_q <= MS_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MS_IDLE && start) begin
			mag_q <= mag;
			lo_q  <= coef;
			acc_q <= '0;
		end
		if (state_q == MS_PREP) begin
			mag3_q <= {{DIGIT_BITS{1'b0}}, mag_q} + {1'b0, mag_q, 1'b0};
		end
		if (state_q == MS_RUN) begin
			acc_q <= {{DIGIT_BITS{1'b0}}, sum[ACC_BITS-1:DIGIT_BITS]};
			lo_q  <= {sum[DIGIT_BITS-1:0], lo_q[COEF_BITS-1:DIGIT_BITS]};
		end
	end

	assign done      = done_q;
	assign prod_hi   = acc_q[MAG_BITS-1:0];
	assign round_bit = lo_q[COEF_BITS-1];

endmodule

/* rtl/core/interleaved_highpass_slew_limiter_unit.sv */
// ----------------------------------------------------------------------------
// interleaved_highpass_slew_limiter_unit
// Averages each sample with the last output, runs it through one of two
// alternating banks of three one-pole lowpasses, forms the highpass, limits
// its distance from the first-stage value and saturates the result.
//
// in_chan takes one signed sample per request; out_chan returns exactly one
// signed sample per request, in order. Configuration goes through the
// cfg_we / cfg_index / cfg_wdata write port; the user must write it only
// while no request is in flight, as the block itself does not enforce this.
//
// One request at a time: in_chan is ready again in the same cycle in which
// the result becomes valid, and not before. A request passes one averaging
// step, three passes through the shared digit-serial multiplier (difference
// and operand capture, preparation, twelve 2-bit coefficient digits,
// hand-over, state update) and the highpass, error, compare, clamp and
// rounding steps. The result sits in an output register: a stalled receiver
// does not keep the next request out, only the hand-over of the following
// result waits. Reset clears the filter states and the previous output,
// selects the first bank and loads the default coefficients and threshold.
// ----------------------------------------------------------------------------
module interleaved_highpass_slew_limiter_unit #(
	parameter int SAMPLE_BITS         = ihsl_pkg::SAMPLE_BITS_DEF,
	parameter int STATE_FRACTION_BITS = ihsl_pkg::STATE_FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	ihsl_in_if.sink                             in_chan,
	ihsl_out_if.source                          out_chan,
	input  logic                                cfg_we,
	input  logic [ihsl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ihsl_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
	import ihsl_pkg::*;

	localparam int W = SAMPLE_BITS + STATE_FRACTION_BITS;
	localparam int M = W + 1;
	localparam int E = W + 2;
	localparam int F = STATE_FRACTION_BITS;
	localparam int S = SAMPLE_BITS;

	localparam logic [1:0] STAGE_FAST  = 2'd0;
	localparam logic [1:0] STAGE_SLOW1 = 2'd1;
	localparam logic [1:0] STAGE_SLOW2 = 2'd2;

	localparam logic [THRESHOLD_BITS-1:0] THR_MASK =
		THRESHOLD_BITS'((64'd1 << (S - 1)) - 64'd1);
	localparam logic signed [E-1:0] HALF_LSB = E'(64'd1 << (F - 1));
	localparam logic signed [S+1:0] SMAX = (S+2)'((64'd1 << (S - 1)) - 64'd1);
	localparam logic signed [S+1:0] SMIN = ~SMAX;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG,
		ST_DIFF,
		ST_MUL,
		ST_UPD,
		ST_HP,
		ST_ERR,
		ST_CMP,
		ST_CLAMP,
		ST_ROUND
	} state_t;

	state_t                      state_q;
	logic [1:0]                  stage_q;
	logic                        bank_q;
	logic                        out_valid_q;
	logic [COEF_BITS-1:0]        fast_coef_q;
	logic [COEF_BITS-1:0]        slow_coef_q;
	logic [THRESHOLD_BITS-1:0]   thr_q;
	logic signed [S-1:0]         prev_q;
	logic signed [W-1:0]         fast_q  [2];
	logic signed [W-1:0]         slow1_q [2];
	logic signed [W-1:0]         slow2_q [2];

	logic signed [S-1:0]         dry_q;
	logic signed [W-1:0]         avg_q;
	logic                        neg_q;
	logic signed [E-1:0]         hp_q;
	logic signed [E-1:0]         err_q;
	logic signed [E-1:0]         nth_q;
	logic signed [E-1:0]         hpc_q;
	logic                        gt_q;
	logic                        lt_q;
	logic signed [S-1:0]         out_q;

	logic                        bi;
	logic signed [W-1:0]         cur_s;
	logic signed [W-1:0]         tgt;
	logic [COEF_BITS-1:0]        cur_coef;
	logic signed [M-1:0]         d_fwd;
	logic signed [M-1:0]         d_rev;
	logic [M-1:0]                mag;
	logic                        mul_start;
	logic                        mul_done;
	logic [M-1:0]                mul_hi;
	logic                        mul_rnd;
	logic [E-1:0]                step_opnd;
	logic signed [E-1:0]         s_new;
	logic signed [E-1:0]         th_ext;
	logic signed [E-1:0]         fast_ext;
	logic signed [E-1:0]         rnd_sum;
	logic signed [S+1:0]         rnd_shift;
	logic signed [S-1:0]         res;
	logic                        accept;
	logic                        ld_out;

	assign bi        = ~bank_q;
	assign accept    = in_chan.valid && (state_q == ST_IDLE);
	assign ld_out    = (state_q == ST_ROUND) && (!out_valid_q || out_chan.ready);
	assign mul_start = (state_q == ST_DIFF);

	always_comb begin
		unique case (stage_q)
			STAGE_FAST: begin
				cur_s    = fast_q[bi];
				tgt      = avg_q;
				cur_coef = fast_coef_q;
			end
			STAGE_SLOW1: begin
				cur_s    = slow1_q[bi];
				tgt      = fast_q[bi];
				cur_coef = slow_coef_q;
			end
			default: begin
				cur_s    = slow2_q[bi];
				tgt      = slow1_q[bi];
				cur_coef = slow_coef_q;
			end
		endcase
		d_fwd     = {tgt[W-1], tgt} - {cur_s[W-1], cur_s};
		d_rev     = {cur_s[W-1], cur_s} - {tgt[W-1], tgt};
		mag       = d_fwd[M-1] ? d_rev : d_fwd;
		step_opnd = neg_q ? ~{1'b0, mul_hi} : {1'b0, mul_hi};
		s_new     = {{2{cur_s[W-1]}}, cur_s} + step_opnd + E'(mul_rnd ^ neg_q);
		th_ext    = E'(thr_q & THR_MASK) << F;
		fast_ext  = {{2{fast_q[bi][W-1]}}, fast_q[bi]};
		rnd_sum   = hpc_q + HALF_LSB;
		rnd_shift = rnd_sum[E-1:F];
		if (rnd_shift > SMAX) begin
			res = SMAX[S-1:0];
		end else if (rnd_shift < SMIN) begin
			res = SMIN[S-1:0];
		end else begin
			res = rnd_shift[S-1:0];
		end
	end

	ihsl_mul #(
		.MAG_BITS (M)
	) u_ihsl_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mul_start),
		.mag       (mag),
		.coef      (cur_coef),
		.done      (mul_done),
		.prod_hi   (mul_hi),
		.round_bit (mul_rnd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stage_q     <= STAGE_FAST;
			bank_q      <= 1'b1;
			out_valid_q <= 1'b0;
			fast_coef_q <= FAST_COEF_RST;
			slow_coef_q <= SLOW_COEF_RST;
			thr_q       <= THRESHOLD_RST;
			prev_q      <= '0;
			for (int i = 0; i < 2; i++) begin
				fast_q[i]  <= '0;
				slow1_q[i] <= '0;
				slow2_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FAST_COEF: fast_coef_q <= cfg_wdata[COEF_BITS-1:0];
					CFG_SLOW_COEF: slow_coef_q <= cfg_wdata[COEF_BITS-1:0];
					CFG_THRESHOLD: thr_q       <= cfg_wdata[THRESHOLD_BITS-1:0];
					default: ;
				endcase
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_chan.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					stage_q <= STAGE_FAST;
					state_q <= ST_DIFF;
				end
				ST_DIFF: state_q <= ST_MUL;
				ST_MUL: begin
					if (mul_done) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					unique case (stage_q)
						STAGE_FAST:  fast_q[bi]  <= s_new[W-1:0];
						STAGE_SLOW1: slow1_q[bi] <= s_new[W-1:0];
						default:     slow2_q[bi] <= s_new[W-1:0];
					endcase
					if (stage_q == STAGE_SLOW2) begin
						stage_q <= STAGE_FAST;
						state_q <= ST_HP;
					end else begin
						stage_q <= stage_q + 2'd1;
						state_q <= ST_DIFF;
					end
				end
				ST_HP:    state_q <= ST_ERR;
				ST_ERR:   state_q <= ST_CMP;
				ST_CMP:   state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_ROUND;
				ST_ROUND: begin
					if (ld_out) begin
						prev_q  <= res;
						bank_q  <= ~bank_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dry_q <= in_chan.in_sample;
		end
		if (state_q == ST_AVG) begin
			avg_q <= W'({{dry_q[S-1], dry_q} + {prev_q[S-1], prev_q}, {(F-1){1'b0}}});
		end
		if (state_q == ST_DIFF) begin
			neg_q <= d_fwd[M-1];
		end
		if (state_q == ST_HP) begin
			hp_q  <= {{2{dry_q[S-1]}}, dry_q, {F{1'b0}}}
				- {{2{slow2_q[bi][W-1]}}, slow2_q[bi]};
			nth_q <= -th_ext;
		end
		if (state_q == ST_ERR) begin
			err_q <= hp_q - fast_ext;
		end
		if (state_q == ST_CMP) begin
			gt_q <= err_q > th_ext;
			lt_q <= err_q < nth_q;
		end
		if (state_q == ST_CLAMP) begin
			if (gt_q || lt_q) begin
				hpc_q <= fast_ext + (gt_q ? th_ext : nth_q);
			end else begin
				hpc_q <= hp_q;
			end
		end
		if (ld_out) begin
			out_q <= res;
		end
	end

	assign in_chan.ready       = (state_q == ST_IDLE);
	assign out_chan.valid      = out_valid_q;
	assign out_chan.out_sample = out_q;

endmodule

/* rtl/core/ihsl_checker.sv */
// ----------------------------------------------------------------------------
// ihsl_checker
// Port-level checks for the slew limiter unit: output handshake, one request
// in flight at a time, and result timing relative to acceptance.
// ----------------------------------------------------------------------------
module ihsl_checker #(
	parameter int SAMPLE_BITS = ihsl_pkg::SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_sample
);
	import ihsl_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_sample))
		else $error("output sample changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a request");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared one cycle after acceptance");

	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("new result without the input side reopening");

endmodule

bind interleaved_highpass_slew_limiter_unit ihsl_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_ihsl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_chan.valid),
	.in_ready   (in_chan.ready),
	.out_valid  (out_chan.valid),
	.out_ready  (out_chan.ready),
	.out_sample (out_chan.out_sample)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for interleaved_highpass_slew_limiter_unit. A bit-exact
// model of the two alternating lowpass banks, the clamp around the first
// stage and the output saturation predicts every sample. Directed extremes
// come first, then random audio-like traffic under a dozen register
// settings, with random stalls on both channels and one long receiver hold.
// ----------------------------------------------------------------------------
module tb;

	import ihsl_pkg::*;

	localparam int SB  = SAMPLE_BITS_DEF;
	localparam int FB  = STATE_FRACTION_BITS_DEF;
	localparam int ACC = SB + FB;

	localparam longint UNIT = longint'(1) << FB;

	localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

	localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

	localparam int PHASES        = 12;
	localparam int PHASE_SAMPLES = 128;
	localparam int HOLD_AT       = 330;
	localparam int HOLD_CYCLES   = 600;
	localparam int DRAIN_CYCLES  = 64;
	localparam int STALL_LIMIT   = 3000;

	class limiter_scoreboard;
		logic [COEF_BITS-1:0]      fast_coef;
		logic [COEF_BITS-1:0]      slow_coef;
		logic [THRESHOLD_BITS-1:0] threshold;
		logic signed [SB-1:0]      last_output;
		logic signed [ACC-1:0]     fast_lp [2];
		logic signed [ACC-1:0]     slow_lp_a [2];
		logic signed [ACC-1:0]     slow_lp_b [2];
		bit                        bank_zero_next;
		logic signed [SB-1:0]      expected_samples [$];
		int                        failures;
		int                        checked;

		function new();
			fast_coef      = FAST_COEF_RST;
			slow_coef      = SLOW_COEF_RST;
			threshold      = THRESHOLD_RST;
			last_output    = '0;
			bank_zero_next = 1'b1;
			failures       = 0;
			checked        = 0;
			for (int i = 0; i < 2; i++) begin
				fast_lp[i]   = '0;
				slow_lp_a[i] = '0;
				slow_lp_b[i] = '0;
			end
		endfunction

		function void write_register(input logic [CFG_INDEX_BITS-1:0] index,
				input logic [CFG_DATA_BITS-1:0] data);
			case (index)
				CFG_FAST_COEF: fast_coef = data[COEF_BITS-1:0];
				CFG_SLOW_COEF: slow_coef = data[COEF_BITS-1:0];
				CFG_THRESHOLD: threshold = data[THRESHOLD_BITS-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_samples.size();
		endfunction

		// round(diff * coef / 2^24), ties away from zero
		function longint rounded_step(input longint diff, input logic [COEF_BITS-1:0] coef);
			longint unsigned mag;
			longint unsigned hi;
			longint unsigned lo;
			longint unsigned prod;
			mag  = (diff < 0) ? longint'(-diff) : diff;
			hi   = mag >> COEF_BITS;
			lo   = mag & ((longint'(1) << COEF_BITS) - 1);
			prod = hi * coef + ((lo * coef + (longint'(1) << (COEF_BITS - 1))) >> COEF_BITS);
			return (diff < 0) ? -longint'(prod) : longint'(prod);
		endfunction

		function logic signed [SB-1:0] predict_sample(input logic signed [SB-1:0] dry);
			int     bank;
			longint mean;
			longint lim;
			longint f;
			longint s1;
			longint s2;
			longint hp;
			longint res;
			bank = bank_zero_next ? 0 : 1;
			mean = (longint'(dry) + longint'(last_output)) * (UNIT / 2);
			lim  = longint'(threshold) * UNIT;
			f    = fast_lp[bank];
			s1   = slow_lp_a[bank];
			s2   = slow_lp_b[bank];
			f    = f + rounded_step(mean - f, fast_coef);
			s1   = s1 + rounded_step(f - s1, slow_coef);
			s2   = s2 + rounded_step(s1 - s2, slow_coef);
			hp   = longint'(dry) * UNIT - s2;
			if (hp - f > lim)
				hp = f + lim;
			if (hp - f < -lim)
				hp = f - lim;
			res = (hp + UNIT / 2) >>> FB;
			if (res > longint'(SAMPLE_MAX))
				res = SAMPLE_MAX;
			if (res < longint'(SAMPLE_MIN))
				res = SAMPLE_MIN;
			fast_lp[bank]   = f[ACC-1:0];
			slow_lp_a[bank] = s1[ACC-1:0];
			slow_lp_b[bank] = s2[ACC-1:0];
			last_output     = res[SB-1:0];
			bank_zero_next  = !bank_zero_next;
			return res[SB-1:0];
		endfunction

		function void note_request(input logic signed [SB-1:0] dry);
			expected_samples.push_back(predict_sample(dry));
		endfunction

		function void check_result(input logic signed [SB-1:0] actual);
			logic signed [SB-1:0] want;
			if (expected_samples.size() == 0) begin
				$error("out_sample expected none, actual %0d", actual);
				failures++;
				return;
			end
			want = expected_samples.pop_front();
			checked++;
			if (actual !== want) begin
				$error("out_sample expected %0d, actual %0d", want, actual);
				failures++;
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_wdata;

	ihsl_in_if #(.SAMPLE_BITS(SB))  in_chan ();
	ihsl_out_if #(.SAMPLE_BITS(SB)) out_chan ();

	limiter_scoreboard board;
	int                in_gap_max;
	int                out_gap_max;
	int                samples_sent;
	int                settings_loaded;

	interleaved_highpass_slew_limiter_unit #(
		.SAMPLE_BITS(SB),
		.STATE_FRACTION_BITS(FB)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_chan(in_chan),
		.out_chan(out_chan),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic logic [COEF_BITS-1:0] draw_coefficient();
		if ($urandom_range(0, 1))
			return COEF_BITS'($urandom_range(0, 65535));
		return COEF_BITS'($urandom);
	endfunction

	function automatic logic signed [SB-1:0] draw_sample(input logic signed [SB-1:0] prev);
		int unsigned pick;
		pick = $urandom_range(0, 15);
		if (pick < 6)
			return SB'($urandom);
		if (pick == 6)
			return SAMPLE_MAX;
		if (pick == 7)
			return SAMPLE_MIN;
		if (pick < 11)
			return SB'($urandom_range(0, 511)) - SB'(256);
		if (pick < 14)
			return prev + SB'($urandom_range(0, 8191)) - SB'(4096);
		return prev;
	endfunction

	task automatic send_sample(input logic signed [SB-1:0] value);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_chan.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_chan.valid     <= 1'b1;
		in_chan.in_sample <= value;
		do @(posedge clk); while (!in_chan.ready);
		board.note_request(value);
		samples_sent++;
	endtask

	task automatic load_settings(input logic [CFG_DATA_BITS-1:0] fast,
			input logic [CFG_DATA_BITS-1:0] slow, input logic [CFG_DATA_BITS-1:0] thr,
			input bit stray);
		logic [CFG_INDEX_BITS-1:0] idx [4];
		logic [CFG_DATA_BITS-1:0]  val [4];
		int                        n;
		idx = '{CFG_FAST_COEF, CFG_SLOW_COEF, CFG_THRESHOLD, CFG_UNUSED};
		val = '{fast, slow, thr, CFG_DATA_BITS'($urandom)};
		n   = stray ? 4 : 3;
		for (int i = 0; i < n; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= val[i];
			@(posedge clk);
			board.write_register(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	initial begin
		logic signed [SB-1:0]     directed [$];
		logic signed [SB-1:0]     last;
		logic [CFG_DATA_BITS-1:0] fast;
		logic [CFG_DATA_BITS-1:0] slow;
		logic [CFG_DATA_BITS-1:0] thr;
		bit                       stray;
		board             = new();
		samples_sent      = 0;
		settings_loaded   = 0;
		in_gap_max        = 18;
		out_gap_max       = 18;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= CFG_FAST_COEF;
		cfg_wdata         <= '0;
		in_chan.valid     <= 1'b0;
		in_chan.in_sample <= '0;
		out_chan.ready    <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{SB'(0), SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN,
			SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SB'(0), SB'(1), -SB'(1), SAMPLE_MAX, SAMPLE_MIN,
			SAMPLE_MAX, SAMPLE_MIN, SB'('h555555), SB'('hAAAAAA), SB'(2), -SB'(2), SAMPLE_MAX,
			SB'(0)};
		foreach (directed[i])
			send_sample(directed[i]);
		last = '0;

		for (int p = 1; p <= PHASES; p++) begin
			in_chan.valid <= 1'b0;
			while (board.pending() != 0) @(posedge clk);
			fast  = draw_coefficient();
			slow  = draw_coefficient();
			thr   = CFG_DATA_BITS'($urandom);
			stray = $urandom_range(0, 1);
			case (p)
				1: begin
					fast = '1;
					slow = '1;
					thr  = {1'b0, {THRESHOLD_BITS{1'b1}}};
				end
				2: begin
					fast = '0;
					slow = '0;
					thr  = '0;
				end
				3: begin
					fast  = '0;
					stray = 1'b1;
				end
				4: begin
					slow = '0;
					thr  = thr | (CFG_DATA_BITS'(1) << THRESHOLD_BITS);
				end
				5: begin
					fast = '1;
					slow = '0;
					thr  = '0;
				end
				6: begin
					fast = FAST_COEF_RST;
					slow = SLOW_COEF_RST;
					thr  = THRESHOLD_RST;
				end
				default: ;
			endcase
			load_settings(fast, slow, thr, stray);
			in_gap_max  = (p % 3 == 1) ? 0 : 18;
			out_gap_max = (p % 4 == 2) ? 0 : 18;
			repeat (PHASE_SAMPLES) begin
				last = draw_sample(last);
				send_sample(last);
			end
		end

		in_chan.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d samples, checked %0d results under %0d register settings,",
			samples_sent, board.checked, settings_loaded + 1);
		$display("including zero and full-scale coefficients and thresholds and a %0d-cycle hold.",
			HOLD_CYCLES);
		if (board.failures == 0 && board.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = $urandom_range(0, out_gap_max);
			if (board.checked == HOLD_AT)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				out_chan.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_chan.ready <= 1'b1;
			do @(posedge clk); while (!out_chan.valid);
			board.check_result(out_chan.out_sample);
		end
	end

	initial begin
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
				idle = 0;
			else
				idle++;
		end
		$display("Regression FAIL");
		$finish;
	end

endmodule
